// File: src/odwm_pkg.sv
// shared types, constants and table builder for the omni drive wheel mixer
package odwm_pkg;

   localparam int HEADING_BITS = 12;
   localparam int DUTY_BITS    = 13;
   localparam int QSTEPS       = 1 << (HEADING_BITS - 2);
   localparam int ADDR_W       = HEADING_BITS - 1;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 20;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DEN [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHEEL_SINE   = 4'd0,
      CSR_WHEEL_COSINE = 4'd1,
      CSR_ALPHA        = 4'd2,
      CSR_MIN_DUTY     = 4'd3,
      CSR_GAIN_FL      = 4'd4,
      CSR_GAIN_FR      = 4'd5,
      CSR_GAIN_BL      = 4'd6,
      CSR_GAIN_BR      = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0]      speed_command;
      logic [HEADING_BITS-1:0] heading;
   } req_word_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty_front_left;
      logic [DUTY_BITS-1:0] duty_front_right;
      logic [DUTY_BITS-1:0] duty_back_left;
      logic [DUTY_BITS-1:0] duty_back_right;
      logic                 dir_front_left;
      logic                 dir_front_right;
      logic                 dir_back_left;
      logic                 dir_back_right;
   } rsp_word_type;

   typedef logic [15:0] sine_rom_type [0:QSTEPS];

   // quarter-wave sine from a truncated taylor series, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  t;
      logic [63:0]  t2;
      logic [63:0]  term;
      logic [63:0]  pos;
      logic [63:0]  neg;
      logic [63:0]  s;
      logic [63:0]  v;
      for (int i = 0; i <= QSTEPS; i++) begin
         t    = (HALF_PI_Q30 * 64'(i) + 64'(QSTEPS / 2)) >> (HEADING_BITS - 2);
         t2   = (t * t + (64'd1 << 29)) >> 30;
         term = t;
         pos  = t;
         neg  = 64'd0;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / TAYLOR_DEN[k];
            if (k % 2 == 1) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
         s = (pos > neg) ? pos - neg : 64'd0;
         v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         rom[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
      end
      return rom;
   endfunction

   // divide by 2^s, rounding half away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] r;
      mag  = v[63] ? 64'(-v) : 64'(v);
      half = 64'd1 << (s - 1);
      r    = (mag + half) >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

// File: src/omni_drive_wheel_mixer_core.sv
// four-wheel omni drive mixer with exponential smoothing, one shared multiplier
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+--------------------------
//  req     | req_valid req_ready req_word   | in        | speed and heading word
//  rsp     | rsp_valid rsp_ready rsp_word   | out       | four duties and dir bits
//  csr     | csr_we csr_index csr_wdata     | in        | register write, no wait
//
// from accept to result valid a word passes a table read, four multiplies for the
// translation and a mix step, then five steps per wheel on the single 33x21
// multiplier; a new word is taken only once the previous result has been loaded
// the next word is taken in the cycle after the result is loaded, while it waits
// a stalled result holds in the output register; the sequencer waits to load it
// synchronous reset restores register defaults and clears the smoothed values
module omni_drive_wheel_mixer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  odwm_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output odwm_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_we,
   input  logic [odwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [odwm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import odwm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ROM, S_XA, S_XB, S_YA, S_YB, S_MIX,
      S_GAIN, S_FRESH, S_AVG, S_UPD, S_DUTY, S_PUSH
   } state_type;

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [16:0]  DMAX     = 17'((1 << DUTY_BITS) - 1);

   // configuration
   logic signed [15:0] wheel_sine_ff;
   logic signed [15:0] wheel_cosine_ff;
   logic [16:0]        alpha_ff;
   logic [12:0]        min_duty_ff;
   logic [19:0]        gain_ff [4];

   // smoothed wheel values, 8 fraction bits
   logic signed [21:0] prev_ff [4];

   state_type               state_ff, state_in;
   logic [1:0]              wheel_ff;
   logic signed [15:0]      speed_ff;
   logic [ADDR_W-1:0]       addr_s_ff, addr_c_ff;
   logic                    neg_s_ff, neg_c_ff;
   logic [15:0]             sin_raw_ff, cos_raw_ff;
   logic signed [53:0]      prod_ff;
   logic signed [53:0]      x_ff;
   logic signed [32:0]      sum_ff, dif_ff;
   logic signed [24:0]      diff_ff;
   logic signed [21:0]      avg_ff;
   logic [DUTY_BITS-1:0]    duty_ff [4];
   logic [3:0]              dir_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   // heading to table address, quadrant folding
   logic [HEADING_BITS-1:0]   head_c;
   logic [HEADING_BITS-3:0]   idx_s, idx_c;
   logic [ADDR_W-1:0]         req_addr_s, req_addr_c;

   assign head_c = req_word.heading + HEADING_BITS'(QSTEPS);
   assign idx_s  = req_word.heading[HEADING_BITS-3:0];
   assign idx_c  = head_c[HEADING_BITS-3:0];
   assign req_addr_s = req_word.heading[HEADING_BITS-2]
                     ? ADDR_W'(QSTEPS) - ADDR_W'(idx_s) : ADDR_W'(idx_s);
   assign req_addr_c = head_c[HEADING_BITS-2]
                     ? ADDR_W'(QSTEPS) - ADDR_W'(idx_c) : ADDR_W'(idx_c);

   // shared multiplier operand select
   logic signed [16:0] sin_val, cos_val;
   logic signed [32:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [53:0] mul_p;
   logic [16:0]        alpha_eff;
   logic signed [32:0] mix_sel;

   assign sin_val   = neg_s_ff ? -$signed({1'b0, sin_raw_ff}) : $signed({1'b0, sin_raw_ff});
   assign cos_val   = neg_c_ff ? -$signed({1'b0, cos_raw_ff}) : $signed({1'b0, cos_raw_ff});
   // alpha above one acts as one
   assign alpha_eff = (alpha_ff > 17'd65536) ? 17'd65536 : alpha_ff;
   // front-left and back-right take x+y, the others y-x
   assign mix_sel   = (wheel_ff == 2'd0 || wheel_ff == 2'd3) ? sum_ff : dif_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_XA: begin
            mul_a = 33'(sin_val);
            mul_b = 21'(wheel_sine_ff);
         end
         S_XB, S_YB: begin
            mul_a = prod_ff[32:0];
            mul_b = 21'(speed_ff);
         end
         S_YA: begin
            mul_a = 33'(cos_val);
            mul_b = 21'(wheel_cosine_ff);
         end
         S_GAIN: begin
            mul_a = mix_sel;
            mul_b = $signed({1'b0, gain_ff[wheel_ff]});
         end
         S_AVG: begin
            mul_a = 33'(diff_ff);
            mul_b = $signed({4'd0, alpha_eff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // add, round and saturation paths
   logic signed [63:0] mix_sum, mix_dif, fresh64, acc64, avg64, r64;
   logic signed [21:0] avg_sat;
   logic [14:0]        r_mag;
   logic [16:0]        mag_sat;
   logic               r_pos;

   assign mix_sum = round_shift(64'(x_ff) + 64'(prod_ff), 15);
   assign mix_dif = round_shift(64'(prod_ff) - 64'(x_ff), 15);
   assign fresh64 = round_shift(64'(prod_ff), 29);
   assign acc64   = 64'(prod_ff) + (64'(prev_ff[wheel_ff]) <<< 16);
   assign avg64   = round_shift(acc64, 16);
   assign avg_sat = (avg64 > 64'sd2097151)  ? 22'sd2097151
                  : (avg64 < -64'sd2097152) ? -22'sd2097152 : avg64[21:0];
   assign r64     = round_shift(64'(avg_ff), 8);
   assign r_pos   = r64 > 64'sd0;
   assign r_mag   = r64[63] ? 15'(-r64) : r64[14:0];
   assign mag_sat = (17'(r_mag) > DMAX) ? DMAX : 17'(r_mag);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_ROM;
         S_ROM:   state_in = S_XA;
         S_XA:    state_in = S_XB;
         S_XB:    state_in = S_YA;
         S_YA:    state_in = S_YB;
         S_YB:    state_in = S_MIX;
         S_MIX:   state_in = S_GAIN;
         S_GAIN:  state_in = S_FRESH;
         S_FRESH: state_in = S_AVG;
         S_AVG:   state_in = S_UPD;
         S_UPD:   state_in = S_DUTY;
         S_DUTY:  state_in = (wheel_ff == 2'd3) ? S_PUSH : S_GAIN;
         S_PUSH:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sine table reads, two ports
   always_ff @(posedge clock) begin
      sin_raw_ff <= SINE_ROM[addr_s_ff];
      cos_raw_ff <= SINE_ROM[addr_c_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         wheel_ff        <= 2'd0;
         rsp_valid_ff    <= 1'b0;
         wheel_sine_ff   <= 16'sd23170;
         wheel_cosine_ff <= 16'sd23170;
         alpha_ff        <= 17'd65536;
         min_duty_ff     <= 13'd0;
         for (int i = 0; i < 4; i++) begin
            gain_ff[i] <= 20'd1048448;
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_WHEEL_SINE:   wheel_sine_ff   <= csr_wdata[15:0];
               CSR_WHEEL_COSINE: wheel_cosine_ff <= csr_wdata[15:0];
               CSR_ALPHA:        alpha_ff        <= csr_wdata[16:0];
               CSR_MIN_DUTY:     min_duty_ff     <= csr_wdata[12:0];
               CSR_GAIN_FL:      gain_ff[0]      <= csr_wdata;
               CSR_GAIN_FR:      gain_ff[1]      <= csr_wdata;
               CSR_GAIN_BL:      gain_ff[2]      <= csr_wdata;
               CSR_GAIN_BR:      gain_ff[3]      <= csr_wdata;
               default: ;
            endcase
         end

         // load a new result when the register is free or drains now
         if (state_ff == S_PUSH && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               wheel_ff <= 2'd0;
               if (req_valid) begin
                  speed_ff  <= req_word.speed_command;
                  addr_s_ff <= req_addr_s;
                  addr_c_ff <= req_addr_c;
                  neg_s_ff  <= req_word.heading[HEADING_BITS-1];
                  neg_c_ff  <= head_c[HEADING_BITS-1];
               end
            end
            S_XA, S_XB, S_YB, S_GAIN, S_AVG: prod_ff <= mul_p;
            S_YA: begin
               x_ff    <= prod_ff;
               prod_ff <= mul_p;
            end
            S_MIX: begin
               sum_ff <= mix_sum[32:0];
               dif_ff <= mix_dif[32:0];
            end
            S_FRESH: diff_ff <= 25'(fresh64) - 25'(prev_ff[wheel_ff]);
            S_UPD: begin
               prev_ff[wheel_ff] <= avg_sat;
               avg_ff            <= avg_sat;
            end
            S_DUTY: begin
               duty_ff[wheel_ff] <= (mag_sat <= 17'(min_duty_ff))
                                  ? '0 : mag_sat[DUTY_BITS-1:0];
               // left wheels mirror the sense of the right ones
               dir_ff[wheel_ff]  <= wheel_ff[0] ? r_pos : !r_pos;
               wheel_ff          <= wheel_ff + 2'd1;
            end
            S_PUSH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_word_ff  <= '{duty_front_left:  duty_ff[0],
                                    duty_front_right: duty_ff[1],
                                    duty_back_left:   duty_ff[2],
                                    duty_back_right:  duty_ff[3],
                                    dir_front_left:   dir_ff[0],
                                    dir_front_right:  dir_ff[1],
                                    dir_back_left:    dir_ff[2],
                                    dir_back_right:   dir_ff[3]};
               end
            end
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a word without leaving idle");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_PUSH))
      else $error("result raised outside the push step");

   a_wheel_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MIX |=> wheel_ff == 2'd0)
      else $error("wheel loop did not start at front-left");

   a_push_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSH && $past(state_ff) == S_DUTY |-> wheel_ff == 2'd0)
      else $error("wheel loop ended early");
`endif

endmodule

// File: tb/sv/odwm_checker.sv
// checker for the omni drive wheel mixer: watches the request, result and register channels, predicts and compares
module odwm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  odwm_pkg::req_word_type         req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  odwm_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_we,
   input  logic [odwm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [odwm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count,
   output int                             duty_words_seen
);
   import odwm_pkg::*;

   localparam int QS = 1 << (HEADING_BITS - 2);

   longint sin_lut [0:QS];
   longint mount_sin, mount_cos;
   longint alpha_q16, min_duty;
   longint wheel_gain [4];
   longint smooth_acc [4];
   rsp_word_type duty_queue [$];

   // quarter-wave table from a truncated taylor series
   initial begin
      longint unsigned t, t2, term, pos, neg, s, v;
      for (int i = 0; i <= QS; i++) begin
         t = (64'd1686629713 * longint'(i) + QS / 2) / QS;
         t2 = (t * t + (64'd1 << 29)) >> 30;
         term = t; pos = t; neg = 0;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) neg += term; else pos += term;
         end
         s = pos > neg ? pos - neg : 0;
         v = (s * 32767 + (64'd1 << 29)) >> 30;
         sin_lut[i] = v > 32767 ? 32767 : v;
      end
   end

   function automatic longint rnd_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 << (s - 1))) >>> s;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint heading_sine(int h);
      int q, i;
      h = h & ((1 << HEADING_BITS) - 1);
      q = h >> (HEADING_BITS - 2);
      i = h & (QS - 1);
      case (q)
         0: return sin_lut[i];
         1: return sin_lut[QS - i];
         2: return -sin_lut[i];
         default: return -sin_lut[QS - i];
      endcase
   endfunction

   function automatic rsp_word_type mix_wheels(req_word_type w);
      rsp_word_type o;
      longint spd, x, y, a, mix, m30, fresh, avg, r, mag;
      logic [DUTY_BITS-1:0] duty [4];
      logic dirv [4];
      spd = longint'(w.speed_command);
      x = heading_sine(w.heading) * mount_sin * spd;
      y = heading_sine(w.heading + QS) * mount_cos * spd;
      a = alpha_q16 > 65536 ? 65536 : alpha_q16;
      for (int k = 0; k < 4; k++) begin
         mix = (k == 0 || k == 3) ? x + y : y - x;
         m30 = rnd_shift(mix, 15);
         fresh = rnd_shift(m30 * wheel_gain[k], 29);
         avg = rnd_shift(a * fresh + (65536 - a) * smooth_acc[k], 16);
         if (avg > 2097151) avg = 2097151;
         if (avg < -2097152) avg = -2097152;
         smooth_acc[k] = avg;
         r = rnd_shift(avg, 8);
         mag = r < 0 ? -r : r;
         if (mag > (1 << DUTY_BITS) - 1) mag = (1 << DUTY_BITS) - 1;
         if (mag <= min_duty) mag = 0;
         duty[k] = DUTY_BITS'(mag);
         // left wheels run mirrored
         dirv[k] = (k == 0 || k == 2) ? !(r > 0) : (r > 0);
      end
      o.duty_front_left = duty[0];
      o.duty_front_right = duty[1];
      o.duty_back_left = duty[2];
      o.duty_back_right = duty[3];
      o.dir_front_left = dirv[0];
      o.dir_front_right = dirv[1];
      o.dir_back_left = dirv[2];
      o.dir_back_right = dirv[3];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         mount_sin <= 23170; mount_cos <= 23170;
         alpha_q16 <= 65536; min_duty <= 0;
         for (int k = 0; k < 4; k++) begin
            wheel_gain[k] <= 1048448;
            smooth_acc[k] = 0;
         end
         duty_queue.delete();
         fail_count = 0;
         duty_words_seen = 0;
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            duty_words_seen++;
            if (duty_queue.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
               fail_count++;
            end else begin
               exp_w = duty_queue.pop_front();
               if (rsp_word !== exp_w) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_w, rsp_word);
                  $display("  duty exp %0d %0d %0d %0d act %0d %0d %0d %0d", exp_w.duty_front_left,
                     exp_w.duty_front_right, exp_w.duty_back_left, exp_w.duty_back_right,
                     rsp_word.duty_front_left, rsp_word.duty_front_right,
                     rsp_word.duty_back_left, rsp_word.duty_back_right);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) duty_queue.push_back(mix_wheels(req_word));
         pending_count = duty_queue.size();
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_WHEEL_SINE:   mount_sin <= longint'($signed(csr_wdata[15:0]));
               CSR_WHEEL_COSINE: mount_cos <= longint'($signed(csr_wdata[15:0]));
               CSR_ALPHA:        alpha_q16 <= longint'(csr_wdata[16:0]);
               CSR_MIN_DUTY:     min_duty <= longint'(csr_wdata[12:0]);
               CSR_GAIN_FL:      wheel_gain[0] <= longint'(csr_wdata);
               CSR_GAIN_FR:      wheel_gain[1] <= longint'(csr_wdata);
               CSR_GAIN_BL:      wheel_gain[2] <= longint'(csr_wdata);
               CSR_GAIN_BR:      wheel_gain[3] <= longint'(csr_wdata);
               default: ;
            endcase
         end
      end
   end
endmodule

// File: tb/sv/tb_omni_drive_wheel_mixer_core.sv
// testbench top for the omni drive wheel mixer: stimulus, register phases and verdict
module tb_omni_drive_wheel_mixer_core;
   import odwm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count, pending_count, duty_words_seen;
   int send_idle_pct = 0;   // chance in a hundred that the sender holds off
   int recv_idle_pct = 0;   // chance in a hundred that the receiver stalls
   int words_sent = 0;

   // 4 time unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   omni_drive_wheel_mixer_core u_dut (.*);

   odwm_checker u_check (.*);

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end

   // present one word and hold it until the block takes it; valid stays up
   // afterwards until the next word or an explicit idle replaces it
   task automatic send_word(input logic signed [15:0] spd, input logic [HEADING_BITS-1:0] hdg);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{speed_command: spd, heading: hdg};
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
   endtask

   // wait until every predicted word has come back, plus drain margin
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // random word: half over the full range, a quarter near the extremes, a quarter near zero
   task automatic send_random();
      logic signed [15:0] spd;
      case ($urandom_range(3))
         0: spd = $urandom_range(1) ? 16'(16'sh7fff - 16'($urandom_range(15)))
                                    : 16'(16'sh8000 + 16'($urandom_range(15)));
         1: spd = 16'($signed(16'($urandom_range(255))) - 16'sd128);
         default: spd = 16'($urandom);
      endcase
      send_word(spd, HEADING_BITS'($urandom));
   endtask

   // one register setting, several within range and the extremes among them
   task automatic load_setting(input int which);
      case (which)
         0: begin
            write_reg(CSR_WHEEL_SINE, 20'h07fff);
            write_reg(CSR_WHEEL_COSINE, 20'h08000);
            write_reg(CSR_ALPHA, 20'h10000);
            write_reg(CSR_MIN_DUTY, 20'd0);
            write_reg(CSR_GAIN_FL, 20'hfffff);
            write_reg(CSR_GAIN_FR, 20'd0);
            write_reg(CSR_GAIN_BL, 20'h80000);
            write_reg(CSR_GAIN_BR, 20'hfffff);
         end
         1: begin
            write_reg(CSR_WHEEL_SINE, 20'h08000);
            write_reg(CSR_WHEEL_COSINE, 20'h07fff);
            write_reg(CSR_ALPHA, 20'h1ffff);    // above one, acts as one
            write_reg(CSR_MIN_DUTY, 20'h01fff);
         end
         2: begin
            write_reg(CSR_ALPHA, 20'd0);        // output frozen at stored value
            write_reg(CSR_MIN_DUTY, 20'd100);
         end
         default: begin
            write_reg(CSR_WHEEL_SINE, 20'($urandom));
            write_reg(CSR_WHEEL_COSINE, 20'($urandom));
            write_reg(CSR_ALPHA, 20'($urandom_range(65536)));
            write_reg(CSR_MIN_DUTY, 20'($urandom_range(1200)));
            write_reg(CSR_GAIN_FL, 20'($urandom));
            write_reg(CSR_GAIN_FR, 20'($urandom));
            write_reg(CSR_GAIN_BL, 20'($urandom));
            write_reg(CSR_GAIN_BR, 20'($urandom));
            write_reg(csr_index_type'(4'd9), 20'($urandom));  // out of range index, ignored
         end
      endcase
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes at reset settings, all quadrants
      send_word(16'sh7fff, 12'd0);
      send_word(16'sh8000, 12'd0);
      send_word(16'sh7fff, 12'd1024);
      send_word(16'sh7fff, 12'd2048);
      send_word(16'sh7fff, 12'd3072);
      send_word(16'sh7fff, 12'd4095);
      send_word(16'sh8000, 12'd512);
      send_word(16'sh0000, 12'd1536);
      send_word(16'sh0001, 12'd2560);
      send_word(-16'sh1, 12'd3584);
      send_word(16'sh5555, 12'haaa);
      send_word(16'sh2aaa, 12'h555);
      drain_block();

      // saturating gains and duty overflow
      load_setting(0);
      send_word(16'sh7fff, 12'd512);
      send_word(16'sh8000, 12'd1536);
      send_word(16'sh7fff, 12'd2560);
      drain_block();

      // minimum duty at its ceiling zeroes everything, dir still tracks sign
      load_setting(1);
      send_word(16'sh7fff, 12'd100);
      send_word(16'sh8000, 12'd3000);
      drain_block();

      load_setting(2);
      send_word(16'sh7fff, 12'd700);
      send_word(16'sh1234, 12'd1900);
      drain_block();

      // random phases: sender light / receiver heavy, then swapped, then neither
      for (int ph = 0; ph < 9; ph++) begin
         send_idle_pct = ph < 3 ? 12 : (ph < 6 ? 72 : 0);
         recv_idle_pct = ph < 3 ? 72 : (ph < 6 ? 12 : 0);
         load_setting(ph == 8 ? 1 : 3);
         for (int n = 0; n < 110; n++) begin
            send_random();
            if (n == 55) begin
               // hold off until every predicted word is back
               req_valid <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
         drain_block();
      end

      drain_block();
      $display("covered %0d words in, %0d duty words checked, over several register settings",
               words_sent, duty_words_seen);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: files.f
src/odwm_pkg.sv
src/omni_drive_wheel_mixer_core.sv
tb/sv/odwm_checker.sv
tb/sv/tb_omni_drive_wheel_mixer_core.sv
